>>> rtl/prepaid_countdown_controller_macros.svh
// Assertion helpers shared by the controller modules.
`ifndef PREPAID_COUNTDOWN_CONTROLLER_MACROS_SVH
`define PREPAID_COUNTDOWN_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pcc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pcc assertion failed");

`endif

>>> rtl/pcc_pkg.sv
`timescale 1ns / 1ps
package pcc_pkg;

  localparam int unsigned SaveIntervalDefault = 10;

  localparam logic [15:0] MaxAddDefault       = 16'd28800;
  localparam logic [15:0] MaxRemainingDefault = 16'd28800;
  localparam logic [15:0] WarnAtDefault       = 16'd60;
  localparam logic [7:0]  FinalDefault        = 8'd10;

  localparam int unsigned SecPerMin  = 60;
  localparam int unsigned DigitScale = 100;
  localparam int unsigned MinMax     = DigitScale - 1;
  localparam int unsigned DispMax    = DigitScale * DigitScale - 1;

  // floor(r / 60) = (r * MinRecip) >> MinShift for 16-bit r
  localparam int unsigned MinRecip  = 34953;
  localparam int unsigned MinShift  = 21;
  // floor(r / 3600) = (r * HourRecip) >> HourShift for 16-bit r
  localparam int unsigned HourRecip = 74566;
  localparam int unsigned HourShift = 28;

  typedef enum logic [2:0] {
    OpTick     = 3'd0,
    OpAddTime  = 3'd1,
    OpPause    = 3'd2,
    OpResume   = 3'd3,
    OpStop     = 3'd4,
    OpButton   = 3'd5,
    OpIdentify = 3'd6,
    OpUnknown  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    PhLocked  = 2'd0,
    PhRunning = 2'd1,
    PhPaused  = 2'd2,
    PhEnded   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    RspOk      = 3'd0,
    RspLimit   = 3'd1,
    RspBad     = 3'd2,
    RspUnknown = 3'd3,
    RspNone    = 3'd4
  } rsp_e;

  typedef enum logic [1:0] {
    BeepNone  = 2'd0,
    BeepShort = 2'd1,
    BeepWarn  = 2'd2,
    BeepEnd   = 2'd3
  } beep_e;

  typedef enum logic [1:0] {
    CfgMaxAdd         = 2'd0,
    CfgMaxRemaining   = 2'd1,
    CfgWarnAt         = 2'd2,
    CfgFinalCountdown = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] max_add;
    logic [15:0] rem_ceiling;
    logic [15:0] warn_at;
    logic [7:0]  final_countdown;
  } cfg_t;

  typedef struct packed {
    rsp_e        response;
    phase_e      phase;
    logic [15:0] remaining;
    logic [31:0] paid_total;
    logic [7:0]  change_count;
    logic        relay_on;
    beep_e       beep_request;
    logic        save_request;
    logic        colon_on;
  } res_t;

endpackage

>>> rtl/pcc_in_if.sv
`timescale 1ns / 1ps
interface pcc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [15:0] seconds;

  modport source (output valid, output operation, output seconds, input ready);
  modport sink (input valid, input operation, input seconds, output ready);
endinterface

>>> rtl/pcc_out_if.sv
`timescale 1ns / 1ps
interface pcc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  response;
  logic [1:0]  phase;
  logic [15:0] remaining;
  logic [31:0] paid_total;
  logic [7:0]  change_count;
  logic        relay_on;
  logic [1:0]  beep_request;
  logic        save_request;
  logic [13:0] display_value;
  logic        colon_on;

  modport source (
    output valid, output response, output phase, output remaining, output paid_total,
    output change_count, output relay_on, output beep_request, output save_request,
    output display_value, output colon_on, input ready
  );
  modport sink (
    input valid, input response, input phase, input remaining, input paid_total,
    input change_count, input relay_on, input beep_request, input save_request,
    input display_value, input colon_on, output ready
  );
endinterface

>>> rtl/pcc_cfg_if.sv
`timescale 1ns / 1ps
interface pcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/pcc_cfg_regs.sv
`timescale 1ns / 1ps
module pcc_cfg_regs (
  input  logic         clk_i,
  input  logic         rst_ni,
  pcc_cfg_if.sink      cfg_i,
  output pcc_pkg::cfg_t cfg_o
);
  import pcc_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_add         <= MaxAddDefault;
      cfg_q.rem_ceiling     <= MaxRemainingDefault;
      cfg_q.warn_at         <= WarnAtDefault;
      cfg_q.final_countdown <= FinalDefault;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CfgMaxAdd:         cfg_q.max_add         <= cfg_i.data;
        CfgMaxRemaining:   cfg_q.rem_ceiling     <= cfg_i.data;
        CfgWarnAt:         cfg_q.warn_at         <= cfg_i.data;
        CfgFinalCountdown: cfg_q.final_countdown <= cfg_i.data[7:0];
        default:           cfg_q                 <= cfg_q;
      endcase
    end
  end
endmodule

>>> rtl/pcc_core.sv
`timescale 1ns / 1ps
`include "prepaid_countdown_controller_macros.svh"
module pcc_core #(
  parameter int unsigned SaveInterval = pcc_pkg::SaveIntervalDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pcc_in_if.sink        in_i,
  input  pcc_pkg::cfg_t cfg_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output pcc_pkg::res_t res_o
);
  import pcc_pkg::*;

  // r % SaveInterval by reciprocal multiply, exact for 16-bit r
  localparam int unsigned    SaveShift  = 16 + $clog2(SaveInterval);
  localparam longint unsigned SaveRecip =
    ((64'd1 << SaveShift) + 64'(SaveInterval) - 64'd1) / 64'(SaveInterval);
  localparam int unsigned    SaveTarget = 1 % SaveInterval;

  logic        a_valid_q;
  op_e         a_op_q;
  logic [15:0] a_sec_q;
  logic        b_valid_q;
  res_t        b_res_q;

  phase_e      phase_q, phase_d;
  logic [15:0] rem_q, rem_d;
  logic [31:0] paid_q, paid_d;
  logic [7:0]  chg_q, chg_d;
  logic        colon_q, colon_d;

  logic        en_a, en_b, upd;
  logic [33:0] save_prod;
  logic [15:0] save_quot, save_mod;
  logic        save_hit;
  logic [15:0] rem_dec;
  logic [16:0] sum;
  logic        enter;
  phase_e      target;
  rsp_e        rsp;
  beep_e       beep;
  logic        save;
  res_t        res_d;

  assign en_b       = !b_valid_q || res_ready_i;
  assign en_a       = !a_valid_q || en_b;
  assign upd        = a_valid_q && en_b;
  assign in_i.ready = en_a;
  assign res_valid_o = b_valid_q;
  assign res_o       = b_res_q;

  assign save_prod = 34'(rem_q) * 34'(SaveRecip);
  assign save_quot = 16'(save_prod >> SaveShift);
  assign save_mod  = rem_q - 16'(32'(save_quot) * 32'(SaveInterval));
  // (r - 1) % N == 0 exactly when r % N == 1 % N
  assign save_hit  = (save_mod == 16'(SaveTarget));
  assign rem_dec   = rem_q - 16'd1;
  assign sum       = {1'b0, rem_q} + {1'b0, a_sec_q};

  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    paid_d  = paid_q;
    chg_d   = chg_q;
    colon_d = colon_q;
    rsp     = RspNone;
    beep    = BeepNone;
    save    = 1'b0;
    enter   = 1'b0;
    target  = phase_q;
    unique case (a_op_q)
      OpTick: begin
        if (phase_q == PhRunning && rem_q != 16'd0) begin
          colon_d = ~colon_q;
          rem_d   = rem_dec;
          if (rem_dec == cfg_i.warn_at) begin
            beep = BeepWarn;
          end else if (rem_dec <= {8'd0, cfg_i.final_countdown} && rem_dec != 16'd0) begin
            beep = BeepShort;
          end
          if (rem_dec != 16'd0 && save_hit) begin
            save = 1'b1;
          end
          if (rem_dec == 16'd0) begin
            enter  = 1'b1;
            target = PhEnded;
            save   = 1'b1;
            beep   = BeepEnd;
          end
        end
      end
      OpAddTime: begin
        beep = BeepShort;
        if (a_sec_q > cfg_i.max_add) begin
          rsp = RspLimit;
        end else if (a_sec_q == 16'd0) begin
          rsp = RspBad;
        end else begin
          if (sum > {1'b0, cfg_i.rem_ceiling}) begin
            rem_d = cfg_i.rem_ceiling;
          end else begin
            rem_d = sum[15:0];
          end
          paid_d = paid_q + 32'(a_sec_q);
          enter  = 1'b1;
          target = (phase_q == PhLocked || phase_q == PhEnded) ? PhRunning : phase_q;
          save   = 1'b1;
          rsp    = RspOk;
        end
      end
      OpPause: begin
        beep = BeepShort;
        if (rem_q != 16'd0 && phase_q == PhRunning) begin
          enter  = 1'b1;
          target = PhPaused;
          save   = 1'b1;
          rsp    = RspOk;
        end else begin
          rsp = RspBad;
        end
      end
      OpResume: begin
        beep = BeepShort;
        if (rem_q == 16'd0) begin
          rsp = RspBad;
        end else begin
          enter  = 1'b1;
          target = PhRunning;
          save   = 1'b1;
          rsp    = RspOk;
        end
      end
      OpStop: begin
        beep   = BeepShort;
        rem_d  = 16'd0;
        paid_d = 32'd0;
        enter  = 1'b1;
        target = PhLocked;
        save   = 1'b1;
        rsp    = RspOk;
      end
      OpButton: begin
        if (phase_q == PhPaused && rem_q != 16'd0) begin
          enter  = 1'b1;
          target = PhRunning;
          save   = 1'b1;
          beep   = BeepShort;
        end
      end
      OpIdentify: begin
        beep = BeepShort;
        rsp  = RspOk;
      end
      OpUnknown: begin
        beep = BeepShort;
        rsp  = RspUnknown;
      end
      default: begin
        rsp = RspUnknown;
      end
    endcase
    if (enter) begin
      if (target != phase_q) begin
        phase_d = target;
        chg_d   = chg_q + 8'd1;
      end
      colon_d = 1'b1;
    end
    res_d.response     = rsp;
    res_d.phase        = phase_d;
    res_d.remaining    = rem_d;
    res_d.paid_total   = paid_d;
    res_d.change_count = chg_d;
    res_d.relay_on     = (phase_d == PhRunning) && (rem_d != 16'd0);
    res_d.beep_request = beep;
    res_d.save_request = save;
    res_d.colon_on     = colon_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      phase_q   <= PhLocked;
      rem_q     <= 16'd0;
      paid_q    <= 32'd0;
      chg_q     <= 8'd0;
      colon_q   <= 1'b1;
    end else begin
      if (en_a) begin
        a_valid_q <= in_i.valid;
      end
      if (en_b) begin
        b_valid_q <= a_valid_q;
      end
      if (upd) begin
        phase_q <= phase_d;
        rem_q   <= rem_d;
        paid_q  <= paid_d;
        chg_q   <= chg_d;
        colon_q <= colon_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && in_i.valid) begin
      a_op_q  <= op_e'(in_i.operation);
      a_sec_q <= in_i.seconds;
    end
    if (upd) begin
      b_res_q <= res_d;
    end
  end

  `PCC_ASSERT_NEXT(a_stall_holds_state, clk_i, rst_ni, a_valid_q && !en_b,
                   $stable(phase_q) && $stable(rem_q) && $stable(paid_q))
  `PCC_ASSERT_NEXT(a_count_tracks_phase, clk_i, rst_ni, 1'b1,
                   (chg_q != $past(chg_q)) == (phase_q != $past(phase_q)))
  `PCC_ASSERT_IMPL(a_reject_no_save, clk_i, rst_ni,
                   b_valid_q && (b_res_q.response == RspLimit || b_res_q.response == RspBad),
                   !b_res_q.save_request)
endmodule

>>> rtl/pcc_display.sv
`timescale 1ns / 1ps
`include "prepaid_countdown_controller_macros.svh"
module pcc_display (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  output logic          res_ready_o,
  input  pcc_pkg::res_t res_i,
  pcc_out_if.source     out_o
);
  import pcc_pkg::*;

  logic        c_valid_q;
  res_t        c_res_q;
  logic [10:0] c_mins_q;
  logic [4:0]  c_hours_q;
  logic        c_show_q;
  logic        d_valid_q;
  res_t        d_res_q;
  logic [13:0] d_disp_q;

  logic        en_c, en_d;
  logic [10:0] mins;
  logic [4:0]  hours;
  logic [5:0]  secs, mm;
  logic        long_fmt;
  logic [6:0]  hi;
  logic [5:0]  lo;
  logic [13:0] disp;

  assign en_d        = !d_valid_q || out_o.ready;
  assign en_c        = !c_valid_q || en_d;
  assign res_ready_o = en_c;

  assign mins  = 11'((32'(res_i.remaining) * 32'(MinRecip)) >> MinShift);
  assign hours = 5'((34'(res_i.remaining) * 34'(HourRecip)) >> HourShift);

  assign secs     = 6'(c_res_q.remaining - 16'(c_mins_q) * 16'(SecPerMin));
  assign mm       = 6'(c_mins_q - 11'(c_hours_q) * 11'(SecPerMin));
  assign long_fmt = c_mins_q > 11'(MinMax);
  assign hi       = long_fmt ? 7'(c_hours_q) : 7'(c_mins_q);
  assign lo       = long_fmt ? mm : secs;
  assign disp     = c_show_q ? (14'(hi) * 14'(DigitScale) + 14'(lo)) : 14'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (en_c) begin
        c_valid_q <= res_valid_i;
      end
      if (en_d) begin
        d_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c && res_valid_i) begin
      c_res_q   <= res_i;
      c_mins_q  <= mins;
      c_hours_q <= hours;
      c_show_q  <= (res_i.phase == PhRunning) || (res_i.phase == PhPaused);
    end
    if (en_d && c_valid_q) begin
      d_res_q  <= c_res_q;
      d_disp_q <= disp;
    end
  end

  assign out_o.valid         = d_valid_q;
  assign out_o.response      = d_res_q.response;
  assign out_o.phase         = d_res_q.phase;
  assign out_o.remaining     = d_res_q.remaining;
  assign out_o.paid_total    = d_res_q.paid_total;
  assign out_o.change_count  = d_res_q.change_count;
  assign out_o.relay_on      = d_res_q.relay_on;
  assign out_o.beep_request  = d_res_q.beep_request;
  assign out_o.save_request  = d_res_q.save_request;
  assign out_o.display_value = d_disp_q;
  assign out_o.colon_on      = d_res_q.colon_on;

  `PCC_ASSERT_IMPL(a_blank_when_idle, clk_i, rst_ni, d_valid_q && (d_res_q.phase == PhLocked || d_res_q.phase == PhEnded), d_disp_q == 14'd0)
  `PCC_ASSERT_IMPL(a_disp_in_range, clk_i, rst_ni, d_valid_q, d_disp_q <= 14'(DispMax))
  `PCC_ASSERT_NEXT(a_stall_holds_mid, clk_i, rst_ni, c_valid_q && !en_d, c_valid_q && $stable(c_mins_q) && $stable(c_hours_q))
endmodule

>>> rtl/prepaid_countdown_controller.sv
`timescale 1ns / 1ps
// Prepaid countdown controller.
// in_i carries one item per transfer: an operation code (tick, add time, pause,
// resume, stop, button, identify, unknown) and a seconds amount for add time.
// out_o returns exactly one result per item, in order: response, phase,
// remaining, paid total, change count, relay drive, beep and save requests,
// display value (mmss, or hhmm above 99 minutes) and the colon bit.
// cfg_i writes the four limit registers by index; it is always ready and must
// only be used while no item is in flight.
// Path: a result passes the input register, the state update into the result
// stage, and two display stages.
// Throughput: one item per cycle while out_o does not stall; the state update
// is combinational and the mm:ss conversion is pipelined behind it.
// Reset clears the session to locked with zero time, colon on, limits at their
// defaults, and empties the pipeline.
// When the receiver stalls, each stage holds its item; bubbles are squeezed out
// and in_i.ready drops only once all four stages hold an item.
module prepaid_countdown_controller #(
  parameter int unsigned SaveInterval = pcc_pkg::SaveIntervalDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pcc_cfg_if.sink   cfg_i,
  pcc_in_if.sink    in_i,
  pcc_out_if.source out_o
);
  import pcc_pkg::*;

  cfg_t cfg;
  logic res_valid;
  logic res_ready;
  res_t res;

  pcc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  pcc_core #(
    .SaveInterval (SaveInterval)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  pcc_display u_disp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_o       (out_o)
  );
endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import pcc_pkg::*;

  localparam int unsigned SaveEvery  = SaveIntervalDefault;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleWait = 8;

  typedef struct packed {
    op_e         op;
    logic [15:0] secs;
  } order_t;

  typedef struct packed {
    rsp_e        response;
    phase_e      phase;
    logic [15:0] remaining;
    logic [31:0] paid;
    logic [7:0]  changes;
    logic        relay;
    beep_e       beep;
    logic        save;
    logic [13:0] display;
    logic        colon;
  } report_t;

  logic clk = 1'b1;
  logic rst_n = 1'b0;

  pcc_cfg_if cfg_ch ();
  pcc_in_if  in_ch ();
  pcc_out_if out_ch ();

  prepaid_countdown_controller DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_ch),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  order_t      pending_orders[$];
  report_t     expected_reports[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  logic        in_taken = 1'b0;
  report_t     seen;
  report_t     want;

  logic [15:0] lim_max_add;
  logic [15:0] lim_rem_ceiling;
  logic [15:0] lim_warn;
  logic [7:0]  lim_final;

  phase_e      ses_phase;
  logic [15:0] ses_remaining;
  logic [31:0] ses_paid;
  logic [7:0]  ses_changes;
  logic        ses_colon;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void enter_phase(phase_e nxt);
    if (ses_phase != nxt) begin
      ses_phase   = nxt;
      ses_changes = ses_changes + 8'd1;
    end
    ses_colon = 1'b1;
  endfunction

  function automatic logic [13:0] shown_time();
    int unsigned mins;
    int unsigned secs_part;
    if (ses_phase != PhRunning && ses_phase != PhPaused) return '0;
    mins      = ses_remaining / SecPerMin;
    secs_part = ses_remaining % SecPerMin;
    if (mins > MinMax) return 14'((mins / SecPerMin) * DigitScale + mins % SecPerMin);
    return 14'(mins * DigitScale + secs_part);
  endfunction

  function automatic report_t step_session(order_t ord);
    report_t     r;
    logic [16:0] sum;
    r          = '0;
    r.response = RspNone;
    r.beep     = BeepNone;
    r.save     = 1'b0;
    case (ord.op)
      OpTick: begin
        if (ses_phase == PhRunning && ses_remaining != 0) begin
          ses_colon     = ~ses_colon;
          ses_remaining = ses_remaining - 16'd1;
          if (ses_remaining == lim_warn) r.beep = BeepWarn;
          else if (ses_remaining <= lim_final && ses_remaining != 0) r.beep = BeepShort;
          if (ses_remaining != 0 && ses_remaining % SaveEvery == 0) r.save = 1'b1;
          if (ses_remaining == 0) begin
            enter_phase(PhEnded);
            r.save = 1'b1;
            r.beep = BeepEnd;
          end
        end
      end
      OpAddTime: begin
        r.beep = BeepShort;
        if (ord.secs > lim_max_add) begin
          r.response = RspLimit;
        end else if (ord.secs == 0) begin
          r.response = RspBad;
        end else begin
          sum = {1'b0, ses_remaining} + {1'b0, ord.secs};
          if (sum > {1'b0, lim_rem_ceiling}) sum = {1'b0, lim_rem_ceiling};
          ses_remaining = sum[15:0];
          ses_paid      = ses_paid + {16'd0, ord.secs};
          if (ses_phase == PhLocked || ses_phase == PhEnded) enter_phase(PhRunning);
          else enter_phase(ses_phase);
          r.save     = 1'b1;
          r.response = RspOk;
        end
      end
      OpPause: begin
        r.beep = BeepShort;
        if (ses_remaining != 0 && ses_phase == PhRunning) begin
          enter_phase(PhPaused);
          r.save     = 1'b1;
          r.response = RspOk;
        end else begin
          r.response = RspBad;
        end
      end
      OpResume: begin
        r.beep = BeepShort;
        if (ses_remaining == 0) begin
          r.response = RspBad;
        end else begin
          enter_phase(PhRunning);
          r.save     = 1'b1;
          r.response = RspOk;
        end
      end
      OpStop: begin
        r.beep        = BeepShort;
        ses_remaining = '0;
        ses_paid      = '0;
        enter_phase(PhLocked);
        r.save     = 1'b1;
        r.response = RspOk;
      end
      OpButton: begin
        if (ses_phase == PhPaused && ses_remaining != 0) begin
          enter_phase(PhRunning);
          r.save = 1'b1;
          r.beep = BeepShort;
        end
      end
      OpIdentify: begin
        r.beep     = BeepShort;
        r.response = RspOk;
      end
      default: begin
        r.beep     = BeepShort;
        r.response = RspUnknown;
      end
    endcase
    r.phase     = ses_phase;
    r.remaining = ses_remaining;
    r.paid      = ses_paid;
    r.changes   = ses_changes;
    r.relay     = (ses_phase == PhRunning && ses_remaining != 0);
    r.display   = shown_time();
    r.colon     = ses_colon;
    return r;
  endfunction

  function automatic string describe(report_t r);
    return {$sformatf("rsp=%0d ph=%0d rem=%0d paid=%0d chg=%0d ",
                      r.response, r.phase, r.remaining, r.paid, r.changes),
            $sformatf("relay=%0b beep=%0d save=%0b disp=%0d colon=%0b",
                      r.relay, r.beep, r.save, r.display, r.colon)};
  endfunction

  // accept orders, predict, and check returned reports
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_taken    <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        seen.response  = rsp_e'(out_ch.response);
        seen.phase     = phase_e'(out_ch.phase);
        seen.remaining = out_ch.remaining;
        seen.paid      = out_ch.paid_total;
        seen.changes   = out_ch.change_count;
        seen.relay     = out_ch.relay_on;
        seen.beep      = beep_e'(out_ch.beep_request);
        seen.save      = out_ch.save_request;
        seen.display   = out_ch.display_value;
        seen.colon     = out_ch.colon_on;
        if (expected_reports.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected report: %s", describe(seen));
        end else begin
          want = expected_reports.pop_front();
          if (seen !== want) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
              $display("report mismatch at cycle %0d", cycle_count);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(seen));
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready && pending_orders.size() != 0)
        expected_reports.push_back(step_session(pending_orders.pop_front()));
    end
  end

  always @(negedge clk) begin
    if (!in_ch.valid || in_taken) begin
      if (pending_orders.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_ch.valid     <= 1'b1;
        in_ch.operation <= pending_orders[0].op;
        in_ch.seconds   <= pending_orders[0].secs;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  task automatic write_limit(cfg_idx_e idx, logic [15:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CfgMaxAdd:       lim_max_add     = value;
      CfgMaxRemaining: lim_rem_ceiling = value;
      CfgWarnAt:       lim_warn        = value;
      default:         lim_final       = value[7:0];
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_limits(logic [15:0] max_add, logic [15:0] max_rem, logic [15:0] warn,
                            logic [15:0] fin);
    write_limit(CfgMaxAdd, max_add);
    write_limit(CfgMaxRemaining, max_rem);
    write_limit(CfgWarnAt, warn);
    write_limit(CfgFinalCountdown, fin);
  endtask

  task automatic queue_order(op_e op, logic [15:0] secs);
    order_t ord;
    ord.op   = op;
    ord.secs = secs;
    pending_orders.push_back(ord);
  endtask

  task automatic drain();
    while (pending_orders.size() != 0 || expected_reports.size() != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
  endtask

  // mostly ticks with small top-ups so sessions run out; the rest is command noise
  task automatic queue_random(int unsigned count);
    int unsigned pick;
    logic [15:0] amount;
    repeat (count) begin
      pick   = $urandom_range(99);
      amount = 16'($urandom);
      if (pick < 50) begin
        queue_order(OpTick, amount);
      end else if (pick < 65) begin
        case ($urandom_range(9))
          0:       amount = 16'($urandom);
          1:       amount = '0;
          2:       amount = lim_max_add;
          3:       amount = lim_max_add + 16'd1;
          default: amount = 16'($urandom_range(1, 40));
        endcase
        queue_order(OpAddTime, amount);
      end else if (pick < 71) queue_order(OpPause, amount);
      else if (pick < 77) queue_order(OpResume, amount);
      else if (pick < 80) queue_order(OpStop, amount);
      else if (pick < 86) queue_order(OpButton, amount);
      else if (pick < 91) queue_order(OpIdentify, amount);
      else queue_order(OpUnknown, amount);
    end
    drain();
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.operation   = '0;
    in_ch.seconds     = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CfgMaxAdd;
    cfg_ch.data       = '0;
    lim_max_add       = MaxAddDefault;
    lim_rem_ceiling   = MaxRemainingDefault;
    lim_warn          = WarnAtDefault;
    lim_final         = FinalDefault;
    ses_phase         = PhLocked;
    ses_remaining     = '0;
    ses_paid          = '0;
    ses_changes       = '0;
    ses_colon         = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    queue_order(OpTick, 16'hFFFF);
    queue_order(OpButton, 16'd0);
    queue_order(OpResume, 16'd0);
    queue_order(OpPause, 16'd0);
    queue_order(OpAddTime, 16'd0);
    queue_order(OpAddTime, 16'd28801);
    queue_order(OpAddTime, 16'hFFFF);
    queue_order(OpIdentify, 16'h5A5A);
    queue_order(OpUnknown, 16'hA5A5);
    queue_order(OpAddTime, 16'd1);
    queue_order(OpTick, 16'd0);
    queue_order(OpTick, 16'd0);
    queue_order(OpResume, 16'd0);
    queue_order(OpAddTime, 16'd61);
    queue_order(OpTick, 16'd0);
    queue_order(OpResume, 16'd0);
    queue_order(OpAddTime, 16'd28800);
    queue_order(OpPause, 16'd0);
    queue_order(OpTick, 16'd0);
    queue_order(OpPause, 16'd0);
    queue_order(OpButton, 16'd0);
    queue_order(OpStop, 16'd0);
    queue_order(OpAddTime, 16'd11);
    queue_order(OpTick, 16'd0);
    queue_order(OpTick, 16'd0);
    drain();
    queue_random(90);

    src_idle_pct = 51;
    set_limits(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    queue_random(90);

    src_idle_pct  = 0;
    snk_stall_pct = 51;
    set_limits(16'd40, 16'd50, 16'd25, 16'd0);
    queue_random(90);

    src_idle_pct  = 29;
    snk_stall_pct = 29;
    set_limits(16'd0, 16'd1, 16'hFFFF, 16'd1);
    queue_random(30);

    write_limit(CfgMaxAdd, 16'd300);
    queue_random(35);

    src_idle_pct  = 0;
    snk_stall_pct = 0;
    set_limits(MaxAddDefault, MaxRemainingDefault, WarnAtDefault, {8'hA5, FinalDefault});
    queue_random(90);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk);
    $display("timeout after %0d cycles", cycle_count);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/pcc_pkg.sv
rtl/pcc_in_if.sv
rtl/pcc_out_if.sv
rtl/pcc_cfg_if.sv
rtl/pcc_cfg_regs.sv
rtl/pcc_core.sv
rtl/pcc_display.sv
rtl/prepaid_countdown_controller.sv
sim/testbench.sv
